>>> rtl/rtma_pkg.sv
// Shared types, widths and constants of the ring trimmed moving average.
package rtma_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned WIN_W     = 5;
  localparam int unsigned THR_W     = 16;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned REG_IDX_W = 1;
  localparam int unsigned CNT16_W   = 16;
  localparam int unsigned MUL_AW    = 33;
  localparam int unsigned MUL_BW    = 17;
  localparam int unsigned ALU_W     = MUL_AW + MUL_BW;
  localparam int unsigned NUM_W     = 38;
  localparam int unsigned REM_W     = 5;

  localparam logic [REG_IDX_W-1:0] REG_WINDOW = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_THRESH = 1'b1;

  localparam logic [WIN_W-1:0]  WIN_RESET  = 5'd16;
  localparam logic [THR_W-1:0]  THR_RESET  = 16'd1000;
  localparam logic [MUL_BW-1:0] JUMP_SCALE = 17'd10000;
  localparam logic [CNT16_W-1:0] COUNT_MAX = 16'hFFFF;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_GET = 1'b1;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2
  } alu_op_e;

  typedef struct packed {
    alu_op_e          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  function automatic logic [ALU_W-1:0] sext32(input logic [DATA_W-1:0] v);
    sext32 = {{(ALU_W - DATA_W){v[DATA_W-1]}}, v};
  endfunction

endpackage

>>> rtl/rtma_ring.sv
// Sample ring memory: one write port, one registered read port, per-entry valid bits.
module rtma_ring #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [31:0]              wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [31:0]              rd_data_o
);
  import rtma_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_q;
  logic [DATA_W-1:0] rdata_q;
  logic              rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule

>>> rtl/rtma_alu.sv
// Shared add / subtract / multiply unit driven by the sequencer.
module rtma_alu (
  input  rtma_pkg::alu_req_t           req_i,
  output logic [rtma_pkg::ALU_W-1:0]   y_o
);
  import rtma_pkg::*;

  always_comb begin
    case (req_i.op)
      ALU_ADD: y_o = req_i.a + req_i.b;
      ALU_SUB: y_o = req_i.a - req_i.b;
      ALU_MUL: y_o = {{MUL_BW{1'b0}}, req_i.a[MUL_AW-1:0]} *
                     {{MUL_AW{1'b0}}, req_i.b[MUL_BW-1:0]};
      default: y_o = '0;
    endcase
  end

endmodule

>>> rtl/ring_trimmed_moving_average.sv
// Top level: sequencer, state registers and stream ports of the trimmed moving average.
//
//  channel   dir  signals                               item
//  s_axis    in   tvalid/tready, tdata[31:0], tuser[0]  sample, opcode
//  m_axis    out  tvalid/tready, tdata[31:0], tuser[1:0] average, all_updated/restarted
//  cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i[15:0] window_length, jump_threshold
//
//  Add: a jump check against the reference (skipped when the reference is not positive),
//  then a refill of the N window entries when needed (after reset or a jump restart), then the store.
//  Get: sum over the window, trim of min and max when N > 2, then a 38-step restoring division.
//  One item at a time; s_axis_tready_o is high only in the idle state between items.
//  A finished result waits in the output register while the next item is taken.
//  Reset is asynchronous; the ring reads as zero until written.
module ring_trimmed_moving_average #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [31:0]                         s_axis_tdata_i,   // [31:0] sample
  input  logic [0:0]                          s_axis_tuser_i,   // [0] opcode
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [31:0]                         m_axis_tdata_o,   // [31:0] average
  output logic [1:0]                          m_axis_tuser_o,   // [0] all_updated, [1] restarted
  input  logic                                cfg_we_i,
  input  logic [rtma_pkg::REG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rtma_pkg::CFG_W-1:0]          cfg_data_i
);
  import rtma_pkg::*;

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = (AW > 6) ? AW : 6;

  typedef enum logic [14:0] {
    S_IDLE   = 15'h0001,
    S_JDIFF  = 15'h0002,
    S_JABS   = 15'h0004,
    S_JMUL1  = 15'h0008,
    S_JMUL2  = 15'h0010,
    S_JCMP   = 15'h0020,
    S_FILL   = 15'h0040,
    S_STORE  = 15'h0080,
    S_GSUM   = 15'h0100,
    S_GTRIM1 = 15'h0200,
    S_GTRIM2 = 15'h0400,
    S_GABS   = 15'h0800,
    S_GDIV   = 15'h1000,
    S_GSIGN  = 15'h2000,
    S_OUT    = 15'h4000
  } state_e;

  state_e              state_q, state_d;
  logic [WIN_W-1:0]    win_q, win_d;
  logic [THR_W-1:0]    thr_q, thr_d;
  logic [WIN_W-1:0]    wi_q, wi_d;
  logic                fill_q, fill_d;
  logic [DATA_W-1:0]   ref_q, ref_d;
  logic [CNT16_W-1:0]  count_q, count_d;
  logic [DATA_W-1:0]   sample_q, sample_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                pend_q, pend_d;
  logic                first_q, first_d;
  logic [ALU_W-1:0]    acc_q, acc_d;
  logic [ALU_W-1:0]    prod_q, prod_d;
  logic [DATA_W-1:0]   mn_q, mn_d;
  logic [DATA_W-1:0]   mx_q, mx_d;
  logic [NUM_W-1:0]    num_q, num_d;
  logic [REM_W-1:0]    rem_q, rem_d;
  logic                neg_q, neg_d;
  logic                rflag_q, rflag_d;
  logic [DATA_W-1:0]   res_q, res_d;
  logic                ovld_q, ovld_d;
  logic [DATA_W-1:0]   odata_q, odata_d;
  logic [1:0]          ouser_q, ouser_d;

  logic [WIN_W-1:0]    n_win;
  logic [WIN_W-1:0]    dvs;
  logic [WIN_W-1:0]    pos;
  logic [WIN_W:0]      pos_inc;
  logic [DATA_W:0]     mag;
  logic                ref_pos;
  logic                in_acc;
  logic                div_ok;

  alu_req_t            alu_req;
  logic [ALU_W-1:0]    alu_y;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [DATA_W-1:0]   mem_rdata;

  rtma_alu u_alu (
    .req_i (alu_req),
    .y_o   (alu_y)
  );

  rtma_ring #(
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (sample_q),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata)
  );

  always_comb begin
    if (win_q == '0) begin
      n_win = WIN_W'(1);
    end else if (32'(win_q) > DEPTH) begin
      n_win = WIN_W'(DEPTH);
    end else begin
      n_win = win_q;
    end
  end

  assign dvs     = (n_win > WIN_W'(2)) ? (n_win - WIN_W'(2)) : n_win;
  assign pos     = (wi_q < n_win) ? wi_q : '0;
  assign pos_inc = {1'b0, pos} + (WIN_W + 1)'(1);
  assign mag     = sample_q[DATA_W-1] ? ((DATA_W + 1)'(0) - {1'b1, sample_q})
                                      : {1'b0, sample_q};
  assign ref_pos = !ref_q[DATA_W-1] && (ref_q != '0);
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign div_ok  = !alu_y[ALU_W-1];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o  = odata_q;
  assign m_axis_tuser_o  = ouser_q;

  always_comb begin
    alu_req.op = ALU_ADD;
    alu_req.a  = acc_q;
    alu_req.b  = '0;
    case (state_q)
      S_JDIFF: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = ALU_W'(mag);
        alu_req.b  = sext32(ref_q);
      end
      S_JABS, S_GABS: begin
        if (acc_q[ALU_W-1]) begin
          alu_req.op = ALU_SUB;
          alu_req.a  = '0;
          alu_req.b  = acc_q;
        end
      end
      S_JMUL1: begin
        alu_req.op = ALU_MUL;
        alu_req.b  = ALU_W'(JUMP_SCALE);
      end
      S_JMUL2: begin
        alu_req.op = ALU_MUL;
        alu_req.a  = ALU_W'(ref_q);
        alu_req.b  = ALU_W'({1'b0, thr_q} + MUL_BW'(1));
      end
      S_JCMP: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = prod_q;
        alu_req.b  = acc_q;
      end
      S_GSUM: begin
        alu_req.b = sext32(mem_rdata);
      end
      S_GTRIM1: begin
        alu_req.op = ALU_SUB;
        alu_req.b  = sext32(mx_q);
      end
      S_GTRIM2: begin
        alu_req.op = ALU_SUB;
        alu_req.b  = sext32(mn_q);
      end
      S_GDIV: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = ALU_W'({rem_q, num_q[NUM_W-1]});
        alu_req.b  = ALU_W'(dvs);
      end
      S_GSIGN: begin
        if (neg_q) begin
          alu_req.op = ALU_SUB;
          alu_req.a  = '0;
          alu_req.b  = ALU_W'(num_q);
        end else begin
          alu_req.a  = ALU_W'(num_q);
        end
      end
      default: begin
        alu_req.op = ALU_ADD;
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    win_d     = win_q;
    thr_d     = thr_q;
    wi_d      = wi_q;
    fill_d    = fill_q;
    ref_d     = ref_q;
    count_d   = count_q;
    sample_d  = sample_q;
    cnt_d     = cnt_q;
    pend_d    = pend_q;
    first_d   = first_q;
    acc_d     = acc_q;
    prod_d    = prod_q;
    mn_d      = mn_q;
    mx_d      = mx_q;
    num_d     = num_q;
    rem_d     = rem_q;
    neg_d     = neg_q;
    rflag_d   = rflag_q;
    res_d     = res_q;
    ovld_d    = ovld_q;
    odata_d   = odata_q;
    ouser_d   = ouser_q;
    mem_we    = 1'b0;
    mem_waddr = AW'(pos);
    mem_re    = 1'b0;
    mem_raddr = cnt_q[AW-1:0];

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WINDOW: win_d = cfg_data_i[WIN_W-1:0];
        REG_THRESH: thr_d = cfg_data_i[THR_W-1:0];
        default:    win_d = win_q;
      endcase
    end

    if (ovld_q && m_axis_tready_i) begin
      ovld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          sample_d = s_axis_tdata_i;
          cnt_d    = '0;
          pend_d   = 1'b0;
          first_d  = 1'b1;
          acc_d    = '0;
          rflag_d  = 1'b0;
          state_d  = (s_axis_tuser_i[0] == OP_GET) ? S_GSUM : S_JDIFF;
        end
      end
      S_JDIFF: begin
        acc_d = alu_y;
        if (ref_pos) begin
          state_d = S_JABS;
        end else begin
          state_d = fill_q ? S_FILL : S_STORE;
        end
      end
      S_JABS: begin
        acc_d   = alu_y;
        state_d = S_JMUL1;
      end
      S_JMUL1: begin
        prod_d  = alu_y;
        state_d = S_JMUL2;
      end
      S_JMUL2: begin
        acc_d   = alu_y;
        state_d = S_JCMP;
      end
      S_JCMP: begin
        if (div_ok) begin
          rflag_d = 1'b1;
          wi_d    = '0;
          fill_d  = 1'b1;
          count_d = '0;
          state_d = S_FILL;
        end else begin
          state_d = fill_q ? S_FILL : S_STORE;
        end
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[AW-1:0];
        ref_d     = sample_q;
        cnt_d     = cnt_q + CNT_W'(1);
        if ((cnt_q + CNT_W'(1)) == CNT_W'(n_win)) begin
          fill_d  = 1'b0;
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        mem_we  = 1'b1;
        wi_d    = (pos_inc >= {1'b0, n_win}) ? '0 : pos_inc[WIN_W-1:0];
        if (count_q != COUNT_MAX) begin
          count_d = count_q + CNT16_W'(1);
        end
        res_d   = '0;
        state_d = S_OUT;
      end
      S_GSUM: begin
        if (pend_q) begin
          acc_d   = alu_y;
          first_d = 1'b0;
          if (first_q || ($signed(mem_rdata) < $signed(mn_q))) begin
            mn_d = mem_rdata;
          end
          if (first_q || ($signed(mem_rdata) > $signed(mx_q))) begin
            mx_d = mem_rdata;
          end
        end
        if (cnt_q < CNT_W'(n_win)) begin
          mem_re = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = (n_win > WIN_W'(2)) ? S_GTRIM1 : S_GABS;
          end
        end
      end
      S_GTRIM1: begin
        acc_d   = alu_y;
        state_d = S_GTRIM2;
      end
      S_GTRIM2: begin
        acc_d   = alu_y;
        state_d = S_GABS;
      end
      S_GABS: begin
        num_d   = alu_y[NUM_W-1:0];
        neg_d   = acc_q[ALU_W-1];
        rem_d   = '0;
        cnt_d   = '0;
        state_d = S_GDIV;
      end
      S_GDIV: begin
        rem_d = div_ok ? alu_y[REM_W-1:0] : {rem_q[REM_W-2:0], num_q[NUM_W-1]};
        num_d = {num_q[NUM_W-2:0], div_ok};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          state_d = S_GSIGN;
        end
      end
      S_GSIGN: begin
        res_d   = alu_y[DATA_W-1:0];
        ref_d   = num_q[DATA_W-1:0];
        count_d = '0;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!ovld_q || m_axis_tready_i) begin
          ovld_d  = 1'b1;
          odata_d = res_q;
          ouser_d = {rflag_q, (count_q >= CNT16_W'(n_win))};
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      win_q   <= WIN_RESET;
      thr_q   <= THR_RESET;
      wi_q    <= '0;
      fill_q  <= 1'b1;
      ref_q   <= '0;
      count_q <= '0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      first_q <= 1'b1;
      rflag_q <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      win_q   <= win_d;
      thr_q   <= thr_d;
      wi_q    <= wi_d;
      fill_q  <= fill_d;
      ref_q   <= ref_d;
      count_q <= count_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      first_q <= first_d;
      rflag_q <= rflag_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    acc_q    <= acc_d;
    prod_q   <= prod_d;
    mn_q     <= mn_d;
    mx_q     <= mx_d;
    num_q    <= num_d;
    rem_q    <= rem_d;
    neg_q    <= neg_d;
    res_q    <= res_d;
    odata_q  <= odata_d;
    ouser_q  <= ouser_d;
  end

  a_write_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (32'(mem_waddr) < 32'(n_win)))
    else $error("ring write outside the window");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GDIV) |-> (rem_q < dvs))
    else $error("division remainder not below divisor");

  a_index_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STORE) |=> (wi_q < n_win))
    else $error("write index not wrapped at window length");

endmodule

>>> tb/trimmed_average_checker.sv
// Checker: predicts each result of the trimmed moving average and compares it with the output.
`timescale 1ns / 1ps
module trimmed_average_checker #(
  parameter int DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_valid_i,
  input  logic                           s_ready_i,
  input  logic [31:0]                    s_data_i,   // [31:0] sample
  input  logic [0:0]                     s_user_i,   // [0] opcode
  input  logic                           m_valid_i,
  input  logic                           m_ready_i,
  input  logic [31:0]                    m_data_i,   // [31:0] average
  input  logic [1:0]                     m_user_i,   // [0] all_updated, [1] restarted
  input  logic                           cfg_we_i,
  input  logic [rtma_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [rtma_pkg::CFG_W-1:0]     cfg_data_i,
  output int                             outstanding_o,
  output int                             errors_o,
  output int                             restarts_o
);

  typedef struct packed {
    logic signed [31:0] average;
    logic               all_updated;
    logic               restarted;
  } avg_result_t;

  logic signed [31:0] ring_q [DEPTH];
  int                 wr_idx;
  bit                 fill_pend;
  logic signed [31:0] ref_val;
  int                 upd_cnt;
  int                 win_len;
  int                 thr;
  avg_result_t        pending_results [$];
  avg_result_t        head;
  int                 err_cnt = 0;
  int                 restart_cnt = 0;
  int                 j;

  assign errors_o   = err_cnt;
  assign restarts_o = restart_cnt;

  task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
    if (err_cnt < 100) begin
      $display("tb: mismatch at %0t: %s expected %h got %h", $time, field, want, got);
    end
    err_cnt++;
  endtask

  // Applies one item to the shadow state and returns the result it should produce.
  function automatic avg_result_t apply_item(logic op, logic [31:0] smp);
    avg_result_t res;
    int          n;
    int          pos;
    int          i;
    longint      s;
    longint      refv;
    longint      diff;
    longint      jump;
    longint      sum;
    longint      mn;
    longint      mx;
    longint      v;
    longint      r;
    res = '0;
    n = (win_len < 1) ? 1 : (win_len > DEPTH) ? DEPTH : win_len;
    if (op == rtma_pkg::OP_ADD) begin
      s    = $signed(smp);
      refv = ref_val;
      if (refv != 0 && s != refv) begin
        diff = ((s < 0) ? -s : s) - refv;
        if (diff < 0) begin
          diff = -diff;
        end
        jump = (diff * longint'(rtma_pkg::JUMP_SCALE)) / refv;
        if (jump > thr) begin
          wr_idx        = 0;
          fill_pend     = 1'b1;
          upd_cnt       = 0;
          res.restarted = 1'b1;
        end
      end
      if (fill_pend) begin
        fill_pend = 1'b0;
        ref_val   = smp;
        for (i = 0; i < n; i++) begin
          ring_q[i] = smp;
        end
      end
      pos         = (wr_idx < n) ? wr_idx : 0;
      ring_q[pos] = smp;
      wr_idx      = (pos + 1 >= n) ? 0 : pos + 1;
      if (upd_cnt < rtma_pkg::COUNT_MAX) begin
        upd_cnt++;
      end
    end else begin
      sum = 0;
      mn  = ring_q[0];
      mx  = mn;
      for (i = 0; i < n; i++) begin
        v   = ring_q[i];
        sum += v;
        if (v < mn) begin
          mn = v;
        end
        if (v > mx) begin
          mx = v;
        end
      end
      if (n <= 2) begin
        r = sum / n;
      end else begin
        r = (sum - mx - mn) / (n - 2);
      end
      // |result| keeps only 32 bits, so the most negative value stays negative
      ref_val     = 32'((r < 0) ? -r : r);
      upd_cnt     = 0;
      res.average = 32'(r);
    end
    res.all_updated = (upd_cnt >= n);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (j = 0; j < DEPTH; j++) begin
        ring_q[j] = '0;
      end
      wr_idx    = 0;
      fill_pend = 1'b1;
      ref_val   = '0;
      upd_cnt   = 0;
      win_len   = rtma_pkg::WIN_RESET;
      thr       = rtma_pkg::THR_RESET;
      pending_results.delete();
      outstanding_o <= 0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected item, tdata", '0, m_data_i);
        end else begin
          head = pending_results.pop_front();
          if (m_data_i !== head.average) begin
            report_mismatch("average", head.average, m_data_i);
          end
          if (m_user_i[0] !== head.all_updated) begin
            report_mismatch("all_updated", 32'(head.all_updated), 32'(m_user_i[0]));
          end
          if (m_user_i[1] !== head.restarted) begin
            report_mismatch("restarted", 32'(head.restarted), 32'(m_user_i[1]));
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == rtma_pkg::REG_WINDOW) begin
          win_len = cfg_data_i[4:0];
        end else if (cfg_idx_i == rtma_pkg::REG_THRESH) begin
          thr = cfg_data_i;
        end
      end
      if (s_valid_i && s_ready_i) begin
        head = apply_item(s_user_i[0], s_data_i);
        if (head.restarted) begin
          restart_cnt++;
        end
        pending_results.push_back(head);
      end
      outstanding_o <= pending_results.size();
    end
  end

endmodule

>>> tb/tb.sv
// Testbench top: drives items and register writes into the trimmed moving average, gives the verdict.
`timescale 1ns / 1ps
module tb;

  localparam int DEPTH       = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RUN_ITEMS   = 100;
  localparam int N_PHASES    = 12;

  logic                           clk_i    = 1'b0;
  logic                           rst_ni   = 1'b0;
  logic                           s_valid  = 1'b0;
  logic                           s_ready;
  logic [31:0]                    s_data   = '0;
  logic [0:0]                     s_user   = '0;
  logic                           m_valid;
  logic                           m_ready  = 1'b0;
  logic [31:0]                    m_data;
  logic [1:0]                     m_user;
  logic                           cfg_we   = 1'b0;
  logic [rtma_pkg::REG_IDX_W-1:0] cfg_idx  = '0;
  logic [rtma_pkg::CFG_W-1:0]     cfg_data = '0;

  int          outstanding;
  int          errors;
  int          restarts;
  int          idle_pct   = 0;
  int          stall_pct  = 0;
  int          cycle_cnt  = 0;
  int          item_cnt   = 0;
  int          get_cnt    = 0;
  int          write_cnt  = 0;
  logic [31:0] base_val   = 32'd1000;

  ring_trimmed_moving_average #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data)
  );

  trimmed_average_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_valid),
    .s_ready_i    (s_ready),
    .s_data_i     (s_data),
    .s_user_i     (s_user),
    .m_valid_i    (m_valid),
    .m_ready_i    (m_ready),
    .m_data_i     (m_data),
    .m_user_i     (m_user),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .outstanding_o(outstanding),
    .errors_o     (errors),
    .restarts_o   (restarts)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_ready   <= ($urandom_range(99) >= stall_pct);
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("tb: timeout after %0d cycles", cycle_cnt);
    $display("tb: done, errors");
    $finish;
  end

  task automatic send_item(logic op, logic [31:0] smp);
    while ($urandom_range(99) < idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= smp;
    s_user  <= op;
    @(posedge clk_i);
    while (!s_ready) begin
      @(posedge clk_i);
    end
    item_cnt++;
    if (op == rtma_pkg::OP_GET) begin
      get_cnt++;
    end
  endtask

  // Holds the sender until every result is back and the block has settled.
  task automatic drain_results();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [rtma_pkg::REG_IDX_W-1:0] idx,
                           logic [rtma_pkg::CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    write_cnt++;
  endtask

  // Mostly values near a drifting base, so the window fills without restarting.
  function automatic logic [31:0] pick_sample();
    int sel;
    int span;
    sel = $urandom_range(99);
    if (sel < 10) begin
      base_val = $urandom >> $urandom_range(31);
      if ($urandom_range(1) == 1) begin
        base_val = -base_val;
      end
      return base_val;
    end else if (sel < 60) begin
      span = 1 << $urandom_range(12);
      return base_val + $urandom_range(2 * span) - span;
    end else if (sel < 72) begin
      return -base_val;
    end else if (sel < 87) begin
      return $urandom;
    end
    case ($urandom_range(4))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  initial begin
    int p;
    int k;
    int win;
    int thr;
    int get_pct;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: empty ring, first fill, small jump, restart, extremes
    send_item(rtma_pkg::OP_GET, 32'hFFFF_FFFF);
    send_item(rtma_pkg::OP_ADD, 32'd100);
    send_item(rtma_pkg::OP_ADD, 32'd105);
    send_item(rtma_pkg::OP_ADD, -32'd108);
    send_item(rtma_pkg::OP_ADD, 32'd200);
    send_item(rtma_pkg::OP_GET, 32'h0);
    send_item(rtma_pkg::OP_ADD, 32'h7FFF_FFFF);
    send_item(rtma_pkg::OP_ADD, 32'h8000_0000);
    send_item(rtma_pkg::OP_GET, 32'h0);

    // single entry: most negative average turns the reference negative
    drain_results();
    write_reg(rtma_pkg::REG_WINDOW, 16'd1);
    write_reg(rtma_pkg::REG_THRESH, 16'd0);
    send_item(rtma_pkg::OP_ADD, 32'h8000_0000);
    send_item(rtma_pkg::OP_GET, 32'h0);
    send_item(rtma_pkg::OP_ADD, 32'd5);
    send_item(rtma_pkg::OP_ADD, 32'hFFFF_FFFF);
    send_item(rtma_pkg::OP_GET, 32'h0);

    // two entries: plain mean, truncated toward zero
    drain_results();
    write_reg(rtma_pkg::REG_WINDOW, 16'd2);
    write_reg(rtma_pkg::REG_THRESH, 16'hFFFF);
    send_item(rtma_pkg::OP_ADD, -32'd3);
    send_item(rtma_pkg::OP_ADD, 32'd0);
    send_item(rtma_pkg::OP_GET, 32'h0);

    for (p = 0; p < N_PHASES; p++) begin
      drain_results();
      idle_pct  = 0;
      stall_pct = 0;
      case (p)
        0:  begin win = 16; thr = 1000;  get_pct = 10; end
        1:  begin win = 3;  thr = 0;     get_pct = 25; end
        2:  begin win = 1;  thr = 65535; get_pct = 40; end
        3:  begin win = 2;  thr = 1;     get_pct = 15; end
        4:  begin win = 0;  thr = 500;   get_pct = 30; end
        5:  begin win = 31; thr = 65535; get_pct = 8;  end
        6:  begin win = 17; thr = 2000;  get_pct = 10; end
        7:  begin win = 8;  thr = 100;   get_pct = 20; end
        8:  begin win = 5;  thr = 0;     get_pct = 12; end
        9:  begin win = 16; thr = 10000; get_pct = 5;  end
        default: begin
          win     = $urandom_range(31);
          thr     = $urandom_range(65535);
          get_pct = $urandom_range(4, 40);
        end
      endcase
      // upper bits of the window write are don't-care
      write_reg(rtma_pkg::REG_WINDOW, {11'($urandom_range(2047)), win[4:0]});
      write_reg(rtma_pkg::REG_THRESH, thr[15:0]);
      case (p % 4)
        1:       idle_pct  = 47;
        2:       stall_pct = 47;
        3:       begin idle_pct = 26; stall_pct = 26; end
        default: ;
      endcase
      for (k = 0; k < RUN_ITEMS; k++) begin
        if ($urandom_range(199) == 0) begin
          drain_results();
        end
        if ($urandom_range(99) < get_pct) begin
          send_item(rtma_pkg::OP_GET, $urandom);
        end else begin
          send_item(rtma_pkg::OP_ADD, pick_sample());
        end
      end
    end

    drain_results();
    idle_pct  = 0;
    stall_pct = 0;
    repeat (100) @(posedge clk_i);
    $display("tb: %0d items (%0d gets), %0d register writes over %0d settings, %0d restarts",
             item_cnt, get_cnt, write_cnt, N_PHASES + 3, restarts);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
